[rtl/tmm_pkg.sv]
package tmm_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int ELEM_BITS_DEF = 16;
  localparam int SUM_BITS      = 36;
  localparam int CFG_BITS      = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int COORD_BITS    = 3;
  localparam int IN_VAL_BITS   = 16;

  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [1:0] ST_TILE     = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_A_ROWS    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_A_COLS    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_B_ROWS    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_B_COLS    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_START = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_END   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_COL_START = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_COL_END   = 3'd7;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  typedef struct packed {
    logic [1:0]                    cmd;
    logic [COORD_BITS-1:0]         elem_row;
    logic [COORD_BITS-1:0]         elem_col;
    logic signed [IN_VAL_BITS-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [COORD_BITS-1:0]      tile_row;
    logic [COORD_BITS-1:0]      tile_col;
    logic signed [SUM_BITS-1:0] sum_value;
    logic                       last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  load_a;
    logic                  load_b;
    logic                  rd;
    logic [COORD_BITS-1:0] arow;
    logic [COORD_BITS-1:0] kidx;
    logic [COORD_BITS-1:0] bcol;
    logic                  clr_acc;
    logic                  emit;
    logic                  zero;
    logic [1:0]            status;
    logic [COORD_BITS-1:0] tile_row;
    logic [COORD_BITS-1:0] tile_col;
    logic                  last;
  } ctl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

  function automatic logic [CFG_BITS-1:0] cap_dim(input logic [CFG_BITS-1:0] v,
                                                  input logic [CFG_BITS-1:0] lim);
    cap_dim = (v > lim) ? lim : v;
  endfunction

endpackage

[rtl/tmm_ram.sv]
module tmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tmm_ctrl.sv]
module tmm_ctrl #(
  parameter int MAX_DIM = tmm_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  tmm_pkg::in_item_t                  item,
  input  logic                               cfg_we,
  input  logic [tmm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tmm_pkg::CFG_BITS-1:0]       cfg_data,
  input  tmm_pkg::dp_status_t                dp_status,
  output tmm_pkg::ctl_cmd_t                  cmd
);

  import tmm_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam logic [CFG_BITS-1:0] DIM_LIM = CFG_BITS'(MAX_DIM);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STATUS,
    S_POS,
    S_MAC,
    S_DRAIN
  } state_t;

  state_t state;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;
  logic [1:0]       st_code;

  logic [CFG_BITS-1:0] a_rows, a_cols, b_rows, b_cols;
  logic [CFG_BITS-1:0] row_start, row_end, col_start, col_end;

  logic [CFG_BITS-1:0] th, tw, ar, inner, bc;
  logic [CFG_BITS:0]   arow_w, bcol_w;
  logic                pos_ok, last_pos, row_done, k_last, in_range, accept;

  always_comb begin
    th       = cap_dim(row_end - row_start, DIM_LIM);
    tw       = cap_dim(col_end - col_start, DIM_LIM);
    ar       = cap_dim(a_rows, DIM_LIM);
    inner    = cap_dim(a_cols, DIM_LIM);
    bc       = cap_dim(b_cols, DIM_LIM);
    arow_w   = (CFG_BITS+1)'(row_start) + (CFG_BITS+1)'(i);
    bcol_w   = (CFG_BITS+1)'(col_start) + (CFG_BITS+1)'(j);
    pos_ok   = (arow_w < (CFG_BITS+1)'(ar)) && (bcol_w < (CFG_BITS+1)'(bc)) &&
               (inner != '0);
    row_done = (CFG_BITS'(j) + 1'b1) == tw;
    last_pos = ((CFG_BITS'(i) + 1'b1) == th) && row_done;
    k_last   = (CFG_BITS'(k) + 1'b1) == inner;
    in_range = (CFG_BITS'(item.elem_row) < DIM_LIM) && (CFG_BITS'(item.elem_col) < DIM_LIM);
    accept   = start && (state == S_IDLE);
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load_a   = accept && (item.cmd == CMD_LOAD_A) && in_range;
    cmd.load_b   = accept && (item.cmd == CMD_LOAD_B) && in_range;
    cmd.arow     = COORD_BITS'(arow_w);
    cmd.bcol     = COORD_BITS'(bcol_w);
    cmd.kidx     = COORD_BITS'(k);
    cmd.status   = ST_TILE;
    cmd.tile_row = COORD_BITS'(i);
    cmd.tile_col = COORD_BITS'(j);
    cmd.last     = last_pos;
    case (state)
      S_POS: begin
        if (pos_ok) begin
          cmd.clr_acc = 1'b1;
        end else begin
          cmd.emit = 1'b1;
          cmd.zero = 1'b1;
        end
      end
      S_MAC: begin
        cmd.rd = 1'b1;
      end
      S_DRAIN: begin
        cmd.emit = !dp_status.pipe_busy;
      end
      S_STATUS: begin
        cmd.emit     = 1'b1;
        cmd.zero     = 1'b1;
        cmd.status   = st_code;
        cmd.tile_row = '0;
        cmd.tile_col = '0;
        cmd.last     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      st_code   <= ST_TILE;
      a_rows    <= 4'd8;
      a_cols    <= 4'd8;
      b_rows    <= 4'd8;
      b_cols    <= 4'd8;
      row_start <= 4'd0;
      row_end   <= 4'd8;
      col_start <= 4'd0;
      col_end   <= 4'd8;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_A_ROWS:    a_rows    <= cfg_data;
          REG_A_COLS:    a_cols    <= cfg_data;
          REG_B_ROWS:    b_rows    <= cfg_data;
          REG_B_COLS:    b_cols    <= cfg_data;
          REG_ROW_START: row_start <= cfg_data;
          REG_ROW_END:   row_end   <= cfg_data;
          REG_COL_START: col_start <= cfg_data;
          REG_COL_END:   col_end   <= cfg_data;
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept && (item.cmd == CMD_COMPUTE)) begin
            i <= '0;
            j <= '0;
            if (b_rows != a_cols) begin
              st_code <= ST_MISMATCH;
              state   <= S_STATUS;
            end else if ((row_end <= row_start) || (col_end <= col_start)) begin
              st_code <= ST_EMPTY;
              state   <= S_STATUS;
            end else begin
              state <= S_POS;
            end
          end
        end
        S_STATUS: begin
          state <= S_IDLE;
        end
        S_POS: begin
          if (pos_ok) begin
            k     <= '0;
            state <= S_MAC;
          end else if (last_pos) begin
            state <= S_IDLE;
          end else if (row_done) begin
            j <= '0;
            i <= i + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_MAC: begin
          k <= k + 1'b1;
          if (k_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // The sum is complete once the read and multiply stages are empty.
          if (!dp_status.pipe_busy) begin
            if (last_pos) begin
              state <= S_IDLE;
            end else begin
              state <= S_POS;
              if (row_done) begin
                j <= '0;
                i <= i + 1'b1;
              end else begin
                j <= j + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/tmm_datapath.sv]
module tmm_datapath #(
  parameter int MAX_DIM   = tmm_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = tmm_pkg::ELEM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tmm_pkg::ctl_cmd_t   cmd,
  input  tmm_pkg::in_item_t   item,
  output tmm_pkg::dp_status_t dp_status,
  output logic                result_valid,
  output tmm_pkg::out_item_t  result
);

  import tmm_pkg::*;

  localparam int IDX_W    = $clog2(MAX_DIM);
  localparam int DEPTH    = MAX_DIM * MAX_DIM;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int PROD_W   = 2 * ELEM_BITS;
  localparam int ACC_BITS = PROD_W + 4;
  localparam int CMP_BITS = (ACC_BITS > SUM_BITS) ? ACC_BITS : SUM_BITS;

  logic signed [ELEM_BITS-1:0] elem;
  logic [ADDR_W-1:0]           waddr, a_raddr, b_raddr;
  logic signed [ELEM_BITS-1:0] a_q, b_q;
  logic                        v1, v2;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [CMP_BITS-1:0]  acc_x;
  logic signed [SUM_BITS-1:0]  sum_sat;

  // The loaded value is narrowed to, or sign-extended into, the element width.
  generate
    if (ELEM_BITS <= IN_VAL_BITS) begin : g_narrow
      assign elem = item.elem_value[ELEM_BITS-1:0];
    end else begin : g_widen
      assign elem = ELEM_BITS'(item.elem_value);
    end
  endgenerate

  assign waddr   = ADDR_W'(ADDR_W'(item.elem_row[IDX_W-1:0]) * ADDR_W'(MAX_DIM) +
                           ADDR_W'(item.elem_col[IDX_W-1:0]));
  assign a_raddr = ADDR_W'(ADDR_W'(cmd.arow[IDX_W-1:0]) * ADDR_W'(MAX_DIM) +
                           ADDR_W'(cmd.kidx[IDX_W-1:0]));
  assign b_raddr = ADDR_W'(ADDR_W'(cmd.kidx[IDX_W-1:0]) * ADDR_W'(MAX_DIM) +
                           ADDR_W'(cmd.bcol[IDX_W-1:0]));

  tmm_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_a_ram (
    .clk   (clk),
    .we    (cmd.load_a),
    .waddr (waddr),
    .wdata (elem),
    .re    (cmd.rd),
    .raddr (a_raddr),
    .rdata (a_q)
  );

  tmm_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_b_ram (
    .clk   (clk),
    .we    (cmd.load_b),
    .waddr (waddr),
    .wdata (elem),
    .re    (cmd.rd),
    .raddr (b_raddr),
    .rdata (b_q)
  );

  assign dp_status.pipe_busy = v1 || v2;

  always_comb begin
    acc_x = CMP_BITS'(acc);
    if (acc_x > CMP_BITS'(SUM_MAX)) begin
      sum_sat = SUM_MAX;
    end else if (acc_x < CMP_BITS'(SUM_MIN)) begin
      sum_sat = SUM_MIN;
    end else begin
      sum_sat = SUM_BITS'(acc_x);
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_q * b_q;
    if (cmd.clr_acc) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_BITS'(prod);
    end
    if (cmd.emit) begin
      result.status    <= cmd.status;
      result.tile_row  <= cmd.tile_row;
      result.tile_col  <= cmd.tile_col;
      result.sum_value <= cmd.zero ? '0 : sum_sat;
      result.last      <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v1           <= cmd.rd;
      v2           <= v1;
      result_valid <= cmd.emit;
    end
  end

endmodule

[rtl/tiled_matrix_multiply.sv]
// Load transfer: busy stays low and the next item may start at once.
// Compute transfer: a mismatch or empty tile gives its one result from the status state, registered.
// A tile position outside A or B or with a zero inner dimension gives a zero result at once; every
// other position steps through the inner terms in the single multiply-accumulate, then drains.
// Results leave one per strobe and the receiver cannot stall. Reset restores the
// register defaults and idles the controller; store contents are undefined until loaded.
module tiled_matrix_multiply #(
  parameter int MAX_DIM   = tmm_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = tmm_pkg::ELEM_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  tmm_pkg::in_item_t                item,
  input  logic                             cfg_we,
  input  logic [tmm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [tmm_pkg::CFG_BITS-1:0]     cfg_data,
  output logic                             result_valid,
  output tmm_pkg::out_item_t               result
);

  import tmm_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t dp_status;

  tmm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  tmm_datapath #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .dp_status    (dp_status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

[rtl/tmm_checker.sv]
module tmm_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input tmm_pkg::in_item_t  item,
  input logic               result_valid,
  input tmm_pkg::out_item_t result
);

  import tmm_pkg::*;

  // Only the final result of a compute transfer may appear once the block is idle.
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("non-final result while idle");

  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_TILE) |-> result.last && (result.sum_value == '0))
    else $error("status result is not a lone zero result");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.cmd != CMD_COMPUTE) |=> !result_valid && !busy)
    else $error("load or unused command produced activity");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.cmd == CMD_COMPUTE) |=> busy)
    else $error("compute transfer did not raise busy");

endmodule

bind tiled_matrix_multiply tmm_checker u_tmm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result_valid (result_valid),
  .result       (result)
);
